>>> rtl/core/bfet_pkg.sv
package bfet_pkg;

  localparam int BLOCKS_PER_BYTE = 4;
  localparam int BLK_W           = 64;
  localparam int LEN_W           = 32;
  localparam int OFF_W           = 2;
  localparam int SEG_LEN_W       = 3;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 32;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_END   = 1'b1;
  localparam logic RES_EXTENT = 1'b0;
  localparam logic RES_TOTAL  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_EXTENT_LEN   = 1'b0,
    CFG_COMPARE_WITH_OLD = 1'b1
  } cfg_reg_t;

  // Up to two runs of qualifying blocks inside one byte
  typedef struct packed {
    logic                 s0_vld;
    logic [OFF_W-1:0]     s0_off;
    logic [SEG_LEN_W-1:0] s0_len;
    logic                 s1_vld;
    logic [OFF_W-1:0]     s1_off;
    logic [SEG_LEN_W-1:0] s1_len;
  } seg_t;

  typedef struct packed {
    logic                 is_end;
    logic                 s0_vld;
    logic [BLK_W-1:0]     s0_start;
    logic [SEG_LEN_W-1:0] s0_len;
    logic                 s1_vld;
    logic [BLK_W-1:0]     s1_start;
    logic [SEG_LEN_W-1:0] s1_len;
  } op_t;

  typedef struct packed {
    logic             result_kind;
    logic [BLK_W-1:0] extent_start;
    logic [LEN_W-1:0] extent_len;
    logic [LEN_W-1:0] trimmed_total;
    logic             last;
  } result_t;

  function automatic seg_t seg_split(logic [BLOCKS_PER_BYTE-1:0] m);
    seg_t       s;
    logic       in_run;
    logic [1:0] nseg;
    s      = '0;
    in_run = 1'b0;
    nseg   = 2'd0;
    for (int i = 0; i < BLOCKS_PER_BYTE; i++) begin
      if (m[i]) begin
        if (!in_run) begin
          if (nseg == 2'd0) begin
            s.s0_vld = 1'b1;
            s.s0_off = OFF_W'(i);
            s.s0_len = SEG_LEN_W'(1);
          end else begin
            s.s1_vld = 1'b1;
            s.s1_off = OFF_W'(i);
            s.s1_len = SEG_LEN_W'(1);
          end
          nseg = nseg + 2'd1;
        end else if (nseg == 2'd1) begin
          s.s0_len = s.s0_len + SEG_LEN_W'(1);
        end else begin
          s.s1_len = s.s1_len + SEG_LEN_W'(1);
        end
        in_run = 1'b1;
      end else begin
        in_run = 1'b0;
      end
    end
    return s;
  endfunction

endpackage

>>> rtl/core/bfet_in_if.sv
interface bfet_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] block_base;
  logic [7:0]  new_byte;
  logic [7:0]  ref_byte;

  modport source (output valid, kind, block_base, new_byte, ref_byte, input ready);
  modport sink   (input valid, kind, block_base, new_byte, ref_byte, output ready);
endinterface

>>> rtl/core/bfet_out_if.sv
interface bfet_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [63:0] extent_start;
  logic [31:0] extent_len;
  logic [31:0] trimmed_total;
  logic        last;

  modport source (output valid, result_kind, extent_start, extent_len, trimmed_total, last,
                  input ready);
  modport sink   (input valid, result_kind, extent_start, extent_len, trimmed_total, last,
                  output ready);
endinterface

>>> rtl/core/bfet_front.sv
module bfet_front (
  bfet_in_if.sink         in,
  input  logic            compare_with_old,
  input  logic            q_full,
  output logic            push,
  output bfet_pkg::op_t   op
);

  logic [bfet_pkg::BLOCKS_PER_BYTE-1:0] qual;
  bfet_pkg::seg_t                       seg;

  always_comb begin
    for (int i = 0; i < bfet_pkg::BLOCKS_PER_BYTE; i++) begin
      if (compare_with_old) begin
        qual[i] = ~(in.new_byte[2*i] | in.new_byte[2*i+1]) &
                  (in.ref_byte[2*i] | in.ref_byte[2*i+1]);
      end else begin
        qual[i] = ~(in.ref_byte[2*i] | in.ref_byte[2*i+1]);
      end
    end
  end

  assign seg = bfet_pkg::seg_split(qual);

  always_comb begin
    op.is_end   = (in.kind == bfet_pkg::KIND_END);
    op.s0_vld   = !op.is_end && seg.s0_vld;
    op.s0_start = in.block_base + bfet_pkg::BLK_W'(seg.s0_off);
    op.s0_len   = seg.s0_len;
    op.s1_vld   = !op.is_end && seg.s1_vld;
    op.s1_start = in.block_base + bfet_pkg::BLK_W'(seg.s1_off);
    op.s1_len   = seg.s1_len;
  end

  assign in.ready = !q_full;
  // drop bytes with no qualifying block: they leave the run untouched
  assign push     = in.valid && !q_full && (op.is_end || op.s0_vld);

endmodule

>>> rtl/core/bfet_queue.sv
module bfet_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bfet_pkg::op_t wr_data,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output bfet_pkg::op_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bfet_pkg::op_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("pop from empty queue");
`endif

endmodule

>>> rtl/core/bfet_back.sv
module bfet_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        op_valid,
  input  bfet_pkg::op_t               op,
  output logic                        pop,
  input  logic [bfet_pkg::LEN_W-1:0]  min_extent_len,
  bfet_out_if.source                  out
);

  localparam int BW = bfet_pkg::BLK_W;
  localparam int LW = bfet_pkg::LEN_W;

  logic                             phase, phase_next;
  logic [BW-1:0]                    run_start, run_start_next;
  logic [BW-1:0]                    run_end, run_end_next;
  logic [LW-1:0]                    run_len, run_len_next;
  logic [LW-1:0]                    trim_sum, trim_sum_next;
  bfet_pkg::result_t                res, res_next;
  logic                             out_valid;
  logic                             load;
  logic                             step;
  logic                             out_free;
  logic [BW-1:0]                    seg_start;
  logic [bfet_pkg::SEG_LEN_W-1:0]   seg_len;
  logic                             adj;
  logic [LW-1:0]                    room;
  logic                             fits;
  logic                             old_emit;
  logic                             emit;
  logic [LW-1:0]                    close_len;
  logic                             more;

  assign out_free = !out_valid || out.ready;
  assign step     = op_valid && out_free;

  always_comb begin
    seg_start = phase ? op.s1_start : op.s0_start;
    seg_len   = phase ? op.s1_len : op.s0_len;
    adj       = (run_len != '0) && (run_end == seg_start);
    room      = ~run_len;
    fits      = (room[LW-1:3] != '0) || (room[2:0] >= seg_len);
    old_emit  = (run_len != '0) && (run_len >= min_extent_len);

    phase_next     = phase;
    run_start_next = run_start;
    run_end_next   = run_end;
    run_len_next   = run_len;
    trim_sum_next  = trim_sum;
    res_next       = '0;
    load           = 1'b0;
    emit           = 1'b0;
    close_len      = run_len;
    more           = 1'b0;
    pop            = 1'b0;

    if (op.is_end) begin
      if (!phase && old_emit) begin
        // flush the open run; the total follows in the second phase
        res_next.result_kind  = bfet_pkg::RES_EXTENT;
        res_next.extent_start = run_start;
        res_next.extent_len   = run_len;
        load                  = 1'b1;
        trim_sum_next         = trim_sum + run_len;
        run_len_next          = '0;
        phase_next            = 1'b1;
      end else begin
        res_next.result_kind   = bfet_pkg::RES_TOTAL;
        res_next.trimmed_total = trim_sum;
        res_next.last          = 1'b1;
        load                   = 1'b1;
        run_start_next         = '0;
        run_end_next           = '0;
        run_len_next           = '0;
        trim_sum_next          = '0;
        phase_next             = 1'b0;
        pop                    = step;
      end
    end else begin
      if (adj && fits) begin
        run_len_next = run_len + LW'(seg_len);
      end else if (adj) begin
        // run saturates: close it at full length, rest starts a new run
        close_len      = bfet_pkg::LEN_MAX;
        emit           = 1'b1;
        run_start_next = seg_start + BW'(room[2:0]);
        run_len_next   = LW'(seg_len - room[2:0]);
      end else begin
        emit           = old_emit;
        run_start_next = seg_start;
        run_len_next   = LW'(seg_len);
      end
      run_end_next = seg_start + BW'(seg_len);
      more         = !phase && op.s1_vld;
      if (emit) begin
        res_next.result_kind  = bfet_pkg::RES_EXTENT;
        res_next.extent_start = run_start;
        res_next.extent_len   = close_len;
        // second run in the byte never touches the first: it closes it
        res_next.last         = !(more && (run_len_next >= min_extent_len));
        load                  = 1'b1;
        trim_sum_next         = trim_sum + close_len;
      end
      if (more) begin
        phase_next = 1'b1;
      end else begin
        phase_next = 1'b0;
        pop        = step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      run_start <= '0;
      run_end   <= '0;
      run_len   <= '0;
      trim_sum  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        phase     <= phase_next;
        run_start <= run_start_next;
        run_end   <= run_end_next;
        run_len   <= run_len_next;
        trim_sum  <= trim_sum_next;
      end
      if (step && load) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && load) begin
      res <= res_next;
    end
  end

  assign out.valid         = out_valid;
  assign out.result_kind   = res.result_kind;
  assign out.extent_start  = res.extent_start;
  assign out.extent_len    = res.extent_len;
  assign out.trimmed_total = res.trimmed_total;
  assign out.last          = res.last;

`ifndef SYNTHESIS
  a_phase_has_op: assert property (@(posedge clk) disable iff (rst)
    phase |-> op_valid && (op.is_end || op.s1_vld)) else $error("second phase without work");
  a_total_clears: assert property (@(posedge clk) disable iff (rst)
    (step && op.is_end && res_next.result_kind == bfet_pkg::RES_TOTAL)
      |=> (run_len == '0 && trim_sum == '0 && !phase)) else $error("state not cleared");
`endif

endmodule

>>> rtl/core/bitmap_free_extent_trim.sv
// Free-extent scanner for discard requests. Each bitmap byte item carries
// four blocks at two bits each, lowest pair first; qualifying blocks merge
// into runs, and a run that closes with at least min_extent_len blocks comes
// out as a discard extent and adds to the trimmed total. An end item flushes
// the open run, returns the total with last set and clears all state. The
// front end accepts one item per cycle while its queue (QUEUE_DEPTH entries)
// has room; the back end's run tracker retires one run piece per cycle while
// its output register is free, so a byte whose qualifying blocks form two
// pieces uses a second phase, as does an end item that also flushes an
// extent before the total. Results leave through an output register at one
// per cycle while the sink is ready. No clearing pass follows reset.
module bitmap_free_extent_trim #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  bfet_in_if.sink                            in,
  bfet_out_if.source                         out,
  input  logic                               cfg_we,
  input  logic [bfet_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfet_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [bfet_pkg::LEN_W-1:0] min_extent_len;
  logic                       compare_with_old;
  logic                       q_full;
  logic                       push;
  logic                       pop;
  logic                       op_valid;
  bfet_pkg::op_t              wr_op;
  bfet_pkg::op_t              rd_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_extent_len   <= bfet_pkg::LEN_W'(1);
      compare_with_old <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfet_pkg::CFG_MIN_EXTENT_LEN:   min_extent_len   <= cfg_data[bfet_pkg::LEN_W-1:0];
        bfet_pkg::CFG_COMPARE_WITH_OLD: compare_with_old <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bfet_front u_front (
    .in               (in),
    .compare_with_old (compare_with_old),
    .q_full           (q_full),
    .push             (push),
    .op               (wr_op)
  );

  bfet_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (wr_op),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (op_valid),
    .rd_data  (rd_op)
  );

  bfet_back u_back (
    .clk            (clk),
    .rst            (rst),
    .op_valid       (op_valid),
    .op             (rd_op),
    .pop            (pop),
    .min_extent_len (min_extent_len),
    .out            (out)
  );

endmodule
